// ===== rtl/core/ggpf_pkg.sv =====
// Shared types, field widths, codes and constants for the grid ground point filter.
// No dependencies; imported by every module of the block but ggpf_ram.
package ggpf_pkg;

   // Field widths
   localparam int COORD_W    = 20;
   localparam int INT_W      = 16;
   localparam int KIDX_W     = 16;
   localparam int SUM_W      = 38;
   localparam int COUNT_W    = 17;
   localparam int MAX_W      = 20;
   localparam int SPREAD_W   = 16;
   localparam int MINC_W     = 16;
   localparam int LIMIT_W    = 20;
   localparam int KEPT_W     = 17;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // Grid geometry defaults and cell size in millimeters
   localparam int X_CELLS_DEF = 20;
   localparam int Y_CELLS_DEF = 10;
   localparam int CELL_MM     = 2000;

   // Cell coordinate: quotient bits
   localparam int QUOT_W    = 8;
   // Offset coordinate (signed) and its unsigned low part fed to the reciprocal multiply
   localparam int OFF_W     = 26;
   localparam int REM_W     = OFF_W - 1;
   // Reciprocal of the cell size, rounded up; the rounding error times any offset
   // below 2^REM_W stays under 2^RECIP_SH, so the quotient is exact
   localparam int RECIP_SH  = 36;
   localparam int RECIP_W   = 26;
   localparam logic [RECIP_W-1:0] CELL_RECIP =
      RECIP_W'(((longint'(1) << RECIP_SH) + longint'(CELL_MM) - 1) / longint'(CELL_MM));
   // Flat cell index before range qualification
   localparam int CELL_FULL_W = 17;

   // Shared multiplier and compare widths
   localparam int MUL_A_W = 21;
   localparam int MUL_B_W = COUNT_W + 1;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int CMP_W   = MUL_P_W + 1;

   // Kinds of input word
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACC   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLS   = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SPREAD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_CNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MEAN_LIM = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_KEPT = 2'd3;

   // Configuration reset values
   localparam logic [SPREAD_W-1:0]       SPREAD_RST   = 16'd400;
   localparam logic [MINC_W-1:0]         MIN_CNT_RST  = 16'd3;
   localparam logic signed [LIMIT_W-1:0] MEAN_LIM_RST = 20'sd2000;
   localparam logic [KEPT_W-1:0]         MAX_KEPT_RST = 17'd60000;

   // Cell reset value and saturation points
   localparam logic signed [MAX_W-1:0] CELL_MAX_RST = -20'sd10000;
   localparam logic [COUNT_W-1:0]      COUNT_SAT    = '1;
   localparam logic [KEPT_W-1:0]       KEPT_SAT     = '1;

   // Multiplier operand select
   localparam logic [1:0] MUL_MAX    = 2'd0;
   localparam logic [1:0] MUL_SPREAD = 2'd1;
   localparam logic [1:0] MUL_LIMIT  = 2'd2;

   // One grid cell as stored in memory
   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [COUNT_W-1:0]      count;
      logic signed [MAX_W-1:0] max;
   } cell_entry_type;

   // Controller to datapath commands
   typedef struct packed {
      logic                 capture;
      logic                 clear;
      logic                 div_step;
      logic                 addr_calc;
      logic                 read;
      logic                 latch;
      logic                 mul_en;
      logic [1:0]           mul_sel;
      logic                 write;
      logic                 decide;
   } ggpf_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic rsp_hold;
      logic cell_ok;
   } ggpf_status_type;

endpackage

// ===== rtl/core/ggpf_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module ggpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/ggpf_ctrl.sv =====
// Sequencer of the grid ground point filter: input handshake and datapath commands.
// Depends on ggpf_pkg.
module ggpf_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ggpf_pkg::KIND_W-1:0]   req_kind,
   input  ggpf_pkg::ggpf_status_type     status,
   output ggpf_pkg::ggpf_cmd_type        cmd
);
   import ggpf_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DIV     = 4'd1;
   localparam logic [3:0] S_ADDR    = 4'd2;
   localparam logic [3:0] S_READ    = 4'd3;
   localparam logic [3:0] S_ENTRY   = 4'd4;
   localparam logic [3:0] S_WRITE   = 4'd5;
   localparam logic [3:0] S_MUL_MAX = 4'd6;
   localparam logic [3:0] S_MUL_SPR = 4'd7;
   localparam logic [3:0] S_MUL_LIM = 4'd8;
   localparam logic [3:0] S_DECIDE  = 4'd9;

   logic [3:0]           state_ff, state_in;
   logic                 is_cls_ff, is_cls_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      is_cls_in  = is_cls_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_kind)
                  KIND_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  KIND_ACC: begin
                     is_cls_in  = 1'b0;
                     state_in   = S_DIV;
                  end
                  KIND_CLS: begin
                     is_cls_in  = 1'b1;
                     state_in   = S_DIV;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = S_ADDR;
         end
         S_ADDR: begin
            cmd.addr_calc = 1'b1;
            state_in      = S_READ;
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_ENTRY;
         end
         S_ENTRY: begin
            cmd.latch = 1'b1;
            if (is_cls_ff) begin
               state_in = S_MUL_MAX;
            end else if (status.cell_ok) begin
               state_in = S_WRITE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            state_in  = S_IDLE;
         end
         S_MUL_MAX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_MAX;
            state_in    = S_MUL_SPR;
         end
         S_MUL_SPR: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SPREAD;
            state_in    = S_MUL_LIM;
         end
         S_MUL_LIM: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_LIMIT;
            state_in    = S_DECIDE;
         end
         S_DECIDE: begin
            // Hold until the result register can take a word
            if (!status.rsp_hold) begin
               cmd.decide = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         is_cls_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         is_cls_ff  <= is_cls_in;
      end
   end

   a_decide_cls: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |-> is_cls_ff)
      else $error("ggpf_ctrl: result issued for a non-classify word");

   a_write_acc: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> !is_cls_ff && $past(cmd.latch))
      else $error("ggpf_ctrl: cell write outside an accumulate sequence");

   a_state_known: assert property (@(posedge clock) disable iff (reset)
      state_ff <= S_DECIDE)
      else $error("ggpf_ctrl: sequencer left its state set");

endmodule

// ===== rtl/core/ggpf_dpath.sv =====
// Datapath of the grid ground point filter: cell locate, cell memory, statistics,
// ground test, kept counter, configuration and result register. Depends on ggpf_pkg, ggpf_ram.
module ggpf_dpath #(
   parameter int X_CELLS = ggpf_pkg::X_CELLS_DEF,
   parameter int Y_CELLS = ggpf_pkg::Y_CELLS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ggpf_pkg::ggpf_cmd_type                  cmd,
   output ggpf_pkg::ggpf_status_type               status,
   input  logic signed [ggpf_pkg::COORD_W-1:0]     req_x_in,
   input  logic signed [ggpf_pkg::COORD_W-1:0]     req_y_in,
   input  logic signed [ggpf_pkg::COORD_W-1:0]     req_z_in,
   input  logic [ggpf_pkg::INT_W-1:0]              req_intensity_in,
   input  logic                                    csr_we,
   input  logic [ggpf_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [ggpf_pkg::CSR_DATA_W-1:0]         csr_wdata,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_keep,
   output logic signed [ggpf_pkg::COORD_W-1:0]     rsp_x_out,
   output logic signed [ggpf_pkg::COORD_W-1:0]     rsp_y_out,
   output logic signed [ggpf_pkg::COORD_W-1:0]     rsp_z_out,
   output logic [ggpf_pkg::INT_W-1:0]              rsp_intensity_out,
   output logic [ggpf_pkg::KIDX_W-1:0]             rsp_kept_index
);
   import ggpf_pkg::*;

   localparam int NCELLS = X_CELLS * Y_CELLS;
   localparam int CELL_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;
   localparam int HALF_X = X_CELLS * CELL_MM / 2;
   localparam int HALF_Y = Y_CELLS * CELL_MM / 2;
   localparam int SPAN_X = 2 * HALF_X;
   localparam int SPAN_Y = 2 * HALF_Y;
   localparam int PROD_W = REM_W + RECIP_W;

   // Configuration registers
   logic [SPREAD_W-1:0]       spread_ff;
   logic [MINC_W-1:0]         min_cnt_ff;
   logic signed [LIMIT_W-1:0] mean_lim_ff;
   logic [KEPT_W-1:0]         max_kept_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spread_ff   <= SPREAD_RST;
         min_cnt_ff  <= MIN_CNT_RST;
         mean_lim_ff <= MEAN_LIM_RST;
         max_kept_ff <= MAX_KEPT_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_SPREAD:   spread_ff   <= csr_wdata[SPREAD_W-1:0];
            REG_MIN_CNT:  min_cnt_ff  <= csr_wdata[MINC_W-1:0];
            REG_MEAN_LIM: mean_lim_ff <= signed'(csr_wdata[LIMIT_W-1:0]);
            REG_MAX_KEPT: max_kept_ff <= csr_wdata[KEPT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Captured point word
   logic signed [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic [INT_W-1:0]          int_ff;

   // Shift coordinates to the grid corner and check the open range
   logic signed [OFF_W-1:0] off_x, off_y;
   logic                    in_x, in_y;

   assign off_x = OFF_W'(req_x_in) + OFF_W'(HALF_X);
   assign off_y = OFF_W'(req_y_in) + OFF_W'(HALF_Y);
   assign in_x  = (off_x > 0) && (off_x < OFF_W'(SPAN_X));
   assign in_y  = (off_y > 0) && (off_y < OFF_W'(SPAN_Y));

   // Divide by the cell size: multiply by its reciprocal and keep the integer part
   logic [REM_W-1:0]  rem_x_ff, rem_y_ff;
   logic [PROD_W-1:0] prod_x, prod_y;
   logic [QUOT_W-1:0] qx_ff, qy_ff;
   logic              in_grid_ff;

   assign prod_x = PROD_W'(rem_x_ff) * PROD_W'(CELL_RECIP);
   assign prod_y = PROD_W'(rem_y_ff) * PROD_W'(CELL_RECIP);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff       <= req_x_in;
         y_ff       <= req_y_in;
         z_ff       <= req_z_in;
         int_ff     <= req_intensity_in;
         rem_x_ff   <= off_x[REM_W-1:0];
         rem_y_ff   <= off_y[REM_W-1:0];
         in_grid_ff <= in_x && in_y;
      end else if (cmd.div_step) begin
         qx_ff <= prod_x[RECIP_SH +: QUOT_W];
         qy_ff <= prod_y[RECIP_SH +: QUOT_W];
      end
   end

   // Flatten to a cell number; out-of-grid points park on cell zero
   logic [CELL_FULL_W-1:0] cell_full;
   logic                   cell_ok_in, cell_ok_ff;
   logic [CELL_W-1:0]      cell_ff;

   assign cell_full  = CELL_FULL_W'(qx_ff) + CELL_FULL_W'(qy_ff) * CELL_FULL_W'(X_CELLS);
   assign cell_ok_in = in_grid_ff
                       && ({1'b0, qx_ff} < (QUOT_W + 1)'(X_CELLS))
                       && ({1'b0, qy_ff} < (QUOT_W + 1)'(Y_CELLS));

   always_ff @(posedge clock) begin
      if (cmd.addr_calc) begin
         cell_ok_ff <= cell_ok_in;
         cell_ff    <= cell_ok_in ? cell_full[CELL_W-1:0] : '0;
      end
   end

   // Cell memory with per-cell valid bits; an invalid cell reads as cleared
   cell_entry_type ram_rdata, wr_entry, entry_ff;
   logic [NCELLS-1:0] valid_ff;
   logic              entry_valid_ff;
   logic              ram_we;

   ggpf_ram #(
      .WIDTH ($bits(cell_entry_type)),
      .DEPTH (NCELLS),
      .AW    (CELL_W)
   ) u_cell_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (cell_ff),
      .wdata (wr_entry),
      .re    (cmd.read),
      .raddr (cell_ff),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.clear) begin
         valid_ff <= '0;
      end else if (ram_we) begin
         valid_ff[cell_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         entry_valid_ff <= valid_ff[cell_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         if (entry_valid_ff) begin
            entry_ff <= ram_rdata;
         end else begin
            entry_ff.sum   <= '0;
            entry_ff.count <= '0;
            entry_ff.max   <= CELL_MAX_RST;
         end
      end
   end

   // Accumulate: add height, count the point, raise the maximum
   logic signed [SUM_W-1:0] ent_sum;
   logic signed [MAX_W-1:0] ent_max;

   assign ent_sum = entry_ff.sum;
   assign ent_max = entry_ff.max;

   always_comb begin
      wr_entry.sum   = ent_sum + SUM_W'(z_ff);
      wr_entry.count = entry_ff.count + 1'b1;
      wr_entry.max   = (z_ff > ent_max) ? z_ff : ent_max;
   end

   assign ram_we = cmd.write && cell_ok_ff && (entry_ff.count != COUNT_SAT);

   // Shared multiplier: one product of the cell count per step
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;
   logic signed [MUL_P_W-1:0] prod_max_ff, prod_spr_ff, prod_lim_ff;

   always_comb begin
      case (cmd.mul_sel)
         MUL_MAX:    mul_a = MUL_A_W'(ent_max);
         MUL_SPREAD: mul_a = signed'(MUL_A_W'(spread_ff));
         MUL_LIMIT:  mul_a = MUL_A_W'(mean_lim_ff);
         default:    mul_a = '0;
      endcase
   end

   assign mul_b = signed'({1'b0, entry_ff.count});
   assign mul_p = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MUL_MAX:    prod_max_ff <= mul_p;
            MUL_SPREAD: prod_spr_ff <= mul_p;
            MUL_LIMIT:  prod_lim_ff <= mul_p;
            default: begin
            end
         endcase
      end
   end

   // Kept counter for the frame
   logic [KEPT_W-1:0] kept_total_ff;

   // Ground test on cross-multiplied mean
   logic signed [CMP_W-1:0] spread_diff;
   logic                    spread_ok, mean_ok, count_ok, room_ok, keep_now;

   assign spread_diff = CMP_W'(prod_max_ff) - CMP_W'(ent_sum);
   assign spread_ok   = spread_diff < CMP_W'(prod_spr_ff);
   assign mean_ok     = CMP_W'(ent_sum) < CMP_W'(prod_lim_ff);
   assign count_ok    = entry_ff.count > COUNT_W'(min_cnt_ff);
   assign room_ok     = kept_total_ff < max_kept_ff;
   assign keep_now    = cell_ok_ff && room_ok && count_ok && spread_ok && mean_ok;

   // Advance the kept count on a kept point, stop at saturation
   always_ff @(posedge clock) begin
      if (reset) begin
         kept_total_ff <= '0;
      end else if (cmd.clear) begin
         kept_total_ff <= '0;
      end else if (cmd.decide && keep_now && (kept_total_ff != KEPT_SAT)) begin
         kept_total_ff <= kept_total_ff + 1'b1;
      end
   end

   // Result register
   logic                      rsp_valid_ff;
   logic                      rsp_keep_ff;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [INT_W-1:0]          rsp_int_ff;
   logic [KIDX_W-1:0]         rsp_kidx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.decide) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         rsp_keep_ff <= keep_now;
         rsp_x_ff    <= x_ff;
         rsp_y_ff    <= y_ff;
         rsp_z_ff    <= z_ff;
         rsp_int_ff  <= int_ff;
         rsp_kidx_ff <= keep_now ? kept_total_ff[KIDX_W-1:0] : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_keep          = rsp_keep_ff;
   assign rsp_x_out         = rsp_x_ff;
   assign rsp_y_out         = rsp_y_ff;
   assign rsp_z_out         = rsp_z_ff;
   assign rsp_intensity_out = rsp_int_ff;
   assign rsp_kept_index    = rsp_kidx_ff;

   assign status.rsp_hold = rsp_valid_ff && !rsp_ready;
   assign status.cell_ok  = cell_ok_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |-> !(rsp_valid_ff && !rsp_ready))
      else $error("ggpf_dpath: result word overwritten before it was taken");

   a_kept_step: assert property (@(posedge clock) disable iff (reset)
      cmd.decide && keep_now && (kept_total_ff != KEPT_SAT)
      |=> kept_total_ff == $past(kept_total_ff) + 1'b1)
      else $error("ggpf_dpath: kept counter did not advance on a kept point");

   a_drop_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_keep_ff |-> rsp_kidx_ff == '0)
      else $error("ggpf_dpath: dropped point carries a kept index");

endmodule

// ===== rtl/core/grid_ground_point_filter_unit.sv =====
// Top level of the grid ground point filter: sequencer plus datapath.
// Depends on ggpf_pkg, ggpf_ctrl, ggpf_dpath (which holds ggpf_ram).
//
//   Channel  Direction  Handshake             Word
//   req      in         req_valid/req_ready   kind, x, y, z, intensity
//   rsp      out        rsp_valid/rsp_ready   keep, x, y, z, intensity, kept index
//   csr      in         csr_we                index, write data (no read-back)
//
// Every word is taken in the idle state, where clear and unused kinds also finish.
// An accumulate or classify word then runs the reciprocal multiply that turns x and y
// into cell coordinates (1 step), the cell address, a registered-read access to the
// cell memory (read, then latch) and then the cell write (none off the grid) or the
// shared multiplier (3 steps) and the result load.
// Reset clears the per-cell valid bits at once, so there is no clearing pass.
// A classify word waits in its last step while the result register is still full;
// the input side takes the next word as soon as the result is loaded.
module grid_ground_point_filter_unit #(
   parameter int X_CELLS = ggpf_pkg::X_CELLS_DEF,
   parameter int Y_CELLS = ggpf_pkg::Y_CELLS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [ggpf_pkg::KIND_W-1:0]             req_kind,
   input  logic signed [ggpf_pkg::COORD_W-1:0]     req_x_in,
   input  logic signed [ggpf_pkg::COORD_W-1:0]     req_y_in,
   input  logic signed [ggpf_pkg::COORD_W-1:0]     req_z_in,
   input  logic [ggpf_pkg::INT_W-1:0]              req_intensity_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_keep,
   output logic signed [ggpf_pkg::COORD_W-1:0]     rsp_x_out,
   output logic signed [ggpf_pkg::COORD_W-1:0]     rsp_y_out,
   output logic signed [ggpf_pkg::COORD_W-1:0]     rsp_z_out,
   output logic [ggpf_pkg::INT_W-1:0]              rsp_intensity_out,
   output logic [ggpf_pkg::KIDX_W-1:0]             rsp_kept_index,
   input  logic                                    csr_we,
   input  logic [ggpf_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [ggpf_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import ggpf_pkg::*;

   ggpf_cmd_type    cmd;
   ggpf_status_type status;

   ggpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .status    (status),
      .cmd       (cmd)
   );

   ggpf_dpath #(
      .X_CELLS (X_CELLS),
      .Y_CELLS (Y_CELLS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_x_in          (req_x_in),
      .req_y_in          (req_y_in),
      .req_z_in          (req_z_in),
      .req_intensity_in  (req_intensity_in),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_keep          (rsp_keep),
      .rsp_x_out         (rsp_x_out),
      .rsp_y_out         (rsp_y_out),
      .rsp_z_out         (rsp_z_out),
      .rsp_intensity_out (rsp_intensity_out),
      .rsp_kept_index    (rsp_kept_index)
   );

endmodule
